// ----- sv/dqe_pkg.sv -----
// shared types and constants for the double-ended queue
package dqe_pkg;

  localparam int DEPTH = 256;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int VAL_W = 32;
  localparam int OUT_CNT_W = 9;

  localparam logic signed [VAL_W-1:0] NONE_VALUE = '1;

  // requested action codes
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_QUERY      = 3'd4
  } act_e;

  // per-cycle move of every cell in a chain
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_SHR  = 2'd1,
    CELL_SHL  = 2'd2,
    CELL_PUT  = 2'd3
  } cell_op_e;

  // control broadcast to a chain
  typedef struct packed {
    cell_op_e               op;
    logic [CNT_W-1:0]       put_idx;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

// ----- sv/dqe_cell.sv -----
// one storage cell of a queue chain
module dqe_cell
  import dqe_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [IDX_W-1:0]        cell_idx,
  input  logic signed [VAL_W-1:0] lo_data,
  input  logic signed [VAL_W-1:0] hi_data,
  output logic signed [VAL_W-1:0] data
);

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;

  // pick the new value from a neighbor, the broadcast value or keep
  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      CELL_HOLD: data_nxt = data_r;
      CELL_SHR:  data_nxt = lo_data;
      CELL_SHL:  data_nxt = hi_data;
      CELL_PUT: begin
        if (CNT_W'(cell_idx) == ctl.put_idx) begin
          data_nxt = ctl.value;
        end
      end
      default:   data_nxt = data_r;
    endcase
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ----- sv/dqe_chain.sv -----
// row of cells with the entry at position zero exposed
module dqe_chain
  import dqe_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  output logic signed [VAL_W-1:0] head_data
);

  logic signed [VAL_W-1:0] cell_data [DEPTH];

  // each cell sees its two neighbors; the ends take the broadcast value or hold
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] lo_w;
    logic signed [VAL_W-1:0] hi_w;

    if (i == 0) begin : g_lo_end
      assign lo_w = ctl.value;
    end else begin : g_lo_mid
      assign lo_w = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_hi_end
      assign hi_w = cell_data[i];
    end else begin : g_hi_mid
      assign hi_w = cell_data[i+1];
    end

    dqe_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cell_idx (IDX_W'(i)),
      .lo_data  (lo_w),
      .hi_data  (hi_w),
      .data     (cell_data[i])
    );
  end

  assign head_data = cell_data[0];

endmodule

// ----- sv/double_ended_queue.sv -----
// double-ended queue top level: action decode, entry count and result register
// latency: a result is valid the cycle after its request transfer
// throughput: one request per cycle while results are taken without stall
// every action is applied to the chains as soon as its request transfers, so no action waits
// on another; requests are held off only while a finished result is stalled
// reset: synchronous active-low, clears the count and result valid; cell data is not reset
module double_ended_queue
  import dqe_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_action,
  input  logic signed [VAL_W-1:0]     in_push_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VAL_W-1:0]     out_popped_value,
  output logic [OUT_CNT_W-1:0]        out_count_after,
  output logic                        out_is_empty,
  output logic signed [VAL_W-1:0]     out_front_value,
  output logic signed [VAL_W-1:0]     out_back_value,
  output logic                        out_overflow
);

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic signed [VAL_W-1:0] popped_r;
  logic signed [VAL_W-1:0] popped_nxt;
  logic                    ovf_r;
  logic                    ovf_nxt;

  logic                    in_xfer;
  logic                    full;
  logic                    empty;
  cell_ctl_t               fwd_ctl;
  cell_ctl_t               rev_ctl;
  logic signed [VAL_W-1:0] fwd_head;
  logic signed [VAL_W-1:0] rev_head;

  // hold off requests while a finished result is stalled
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // decode the action into chain moves and the count update
  always_comb begin
    fwd_ctl.op      = CELL_HOLD;
    fwd_ctl.put_idx = count_r;
    fwd_ctl.value   = in_push_value;
    rev_ctl.op      = CELL_HOLD;
    rev_ctl.put_idx = count_r;
    rev_ctl.value   = in_push_value;
    count_nxt       = count_r;
    popped_nxt      = popped_r;
    ovf_nxt         = ovf_r;
    out_valid_nxt   = out_valid_r && out_stall;

    if (in_xfer) begin
      out_valid_nxt = 1'b1;
      popped_nxt    = NONE_VALUE;
      ovf_nxt       = 1'b0;
      unique case (in_action)
        ACT_PUSH_FRONT: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            fwd_ctl.op = CELL_SHR;
            rev_ctl.op = CELL_PUT;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        ACT_PUSH_BACK: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            fwd_ctl.op = CELL_PUT;
            rev_ctl.op = CELL_SHR;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        ACT_POP_FRONT: begin
          if (!empty) begin
            popped_nxt = fwd_head;
            fwd_ctl.op = CELL_SHL;
            count_nxt  = count_r - CNT_W'(1);
          end
        end
        ACT_POP_BACK: begin
          if (!empty) begin
            popped_nxt = rev_head;
            rev_ctl.op = CELL_SHL;
            count_nxt  = count_r - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // front-ordered chain: entry zero is the front
  dqe_chain u_fwd (
    .clk       (clk),
    .ctl       (fwd_ctl),
    .head_data (fwd_head)
  );

  // back-ordered chain: entry zero is the back
  dqe_chain u_rev (
    .clk       (clk),
    .ctl       (rev_ctl),
    .head_data (rev_head)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    ovf_r    <= ovf_nxt;
  end

  // result fields; state does not move while a result waits
  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_count_after  = OUT_CNT_W'(count_r);
  assign out_is_empty     = empty;
  assign out_front_value  = empty ? NONE_VALUE : fwd_head;
  assign out_back_value   = empty ? NONE_VALUE : rev_head;
  assign out_overflow     = ovf_r;

  // count stays within the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // a refused push is only reported with a full queue
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ovf_r) |-> full)
    else $error("overflow reported while not full");

  // a successful pop lowers the count by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !empty && (in_action == ACT_POP_FRONT || in_action == ACT_POP_BACK))
    |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not lower the count");

  // a push at the front shows up at the head of the front-ordered chain
  a_push_front: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !full && in_action == ACT_PUSH_FRONT)
    |=> (fwd_head == $past(in_push_value)))
    else $error("front push not at front");

endmodule

// ----- verif/dqe_checker.sv -----
// result checker for the double-ended queue: ring predictor, expected results and field compare
module dqe_checker
  import dqe_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [2:0]              in_action,
  input  logic signed [VAL_W-1:0] in_push_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [VAL_W-1:0] out_popped_value,
  input  logic [OUT_CNT_W-1:0]    out_count_after,
  input  logic                    out_is_empty,
  input  logic signed [VAL_W-1:0] out_front_value,
  input  logic signed [VAL_W-1:0] out_back_value,
  input  logic                    out_overflow,
  output int                      fail_count,
  output int                      results_waiting,
  output int                      results_seen,
  output int                      refused_pushes,
  output int                      empty_pops,
  output int                      peak_fill
);

  localparam int PRINT_CAP = 40;

  typedef struct {
    logic signed [VAL_W-1:0] popped;
    logic [OUT_CNT_W-1:0]    count;
    logic                    empty;
    logic signed [VAL_W-1:0] front;
    logic signed [VAL_W-1:0] back;
    logic                    overflow;
  } dq_result_t;

  // predicted deque contents
  logic signed [VAL_W-1:0] ring_slot [DEPTH];
  logic [IDX_W-1:0]        head_slot;
  logic [CNT_W-1:0]        live_count;
  dq_result_t              expected_q[$];

  // slot at a distance from the front, wrapping around the ring
  function automatic logic [IDX_W-1:0] ring_at(int offset);
    return IDX_W'((int'(head_slot) + offset) % DEPTH);
  endfunction

  // apply one request to the predicted deque and build its result
  function automatic dq_result_t apply_action(logic [2:0] code, logic signed [VAL_W-1:0] value);
    dq_result_t r;
    r.popped   = NONE_VALUE;
    r.overflow = 1'b0;
    case (code)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (live_count >= DEPTH) begin
          r.overflow = 1'b1;
        end else if (code == ACT_PUSH_FRONT) begin
          head_slot = ring_at(DEPTH - 1);
          ring_slot[head_slot] = value;
          live_count++;
        end else begin
          ring_slot[ring_at(int'(live_count))] = value;
          live_count++;
        end
      end
      ACT_POP_FRONT: begin
        if (live_count != 0) begin
          r.popped  = ring_slot[head_slot];
          head_slot = ring_at(1);
          live_count--;
        end
      end
      ACT_POP_BACK: begin
        if (live_count != 0) begin
          r.popped = ring_slot[ring_at(int'(live_count) - 1)];
          live_count--;
        end
      end
      // query and the unused codes leave the deque alone
      default: ;
    endcase
    r.count = OUT_CNT_W'(live_count);
    r.empty = (live_count == 0);
    r.front = r.empty ? NONE_VALUE : ring_slot[head_slot];
    r.back  = r.empty ? NONE_VALUE : ring_slot[ring_at(int'(live_count) - 1)];
    return r;
  endfunction

  // one line per mismatch, printing capped so a broken block cannot flood the log
  task automatic report_mismatch(string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("dqe_checker: mismatch at %0t: %s", $time, what);
    end
  endtask

  // field by field compare of a result transfer
  task automatic compare_result(dq_result_t want);
    if (out_popped_value !== want.popped) begin
      report_mismatch($sformatf("popped_value %0d, expected %0d", out_popped_value, want.popped));
    end
    if (out_count_after !== want.count) begin
      report_mismatch($sformatf("count_after %0d, expected %0d", out_count_after, want.count));
    end
    if (out_is_empty !== want.empty) begin
      report_mismatch($sformatf("is_empty %0b, expected %0b", out_is_empty, want.empty));
    end
    if (out_front_value !== want.front) begin
      report_mismatch($sformatf("front_value %0d, expected %0d", out_front_value, want.front));
    end
    if (out_back_value !== want.back) begin
      report_mismatch($sformatf("back_value %0d, expected %0d", out_back_value, want.back));
    end
    if (out_overflow !== want.overflow) begin
      report_mismatch($sformatf("overflow %0b, expected %0b", out_overflow, want.overflow));
    end
  endtask

  // results are matched before the same-edge request, which cannot be answered yet
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_q.delete();
      head_slot  = '0;
      live_count = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with no request outstanding");
        end else begin
          compare_result(expected_q[0]);
          expected_q.delete(0);
          results_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        if ((in_action == ACT_POP_FRONT || in_action == ACT_POP_BACK) && live_count == 0) begin
          empty_pops++;
        end
        expected_q.insert(expected_q.size(), apply_action(in_action, in_push_value));
        if (expected_q[$].overflow) begin
          refused_pushes++;
        end
        if (int'(live_count) > peak_fill) begin
          peak_fill = int'(live_count);
        end
      end
    end
    results_waiting = expected_q.size();
  end

endmodule

// ----- verif/tb_double_ended_queue.sv -----
// testbench top for the double-ended queue: clock, reset, request and result traffic, verdict
module tb_double_ended_queue;
  import dqe_pkg::*;

  // codes outside the defined set, which the block treats as a query
  localparam logic [2:0] ACT_SPARE_A = 3'd5;
  localparam logic [2:0] ACT_SPARE_B = 3'd6;
  localparam logic [2:0] ACT_SPARE_C = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  localparam int IDLE_PCT    = 6;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic [2:0]              in_action     = ACT_QUERY;
  logic signed [VAL_W-1:0] in_push_value = '0;
  logic                    out_valid;
  logic                    out_stall     = 1'b0;
  logic signed [VAL_W-1:0] out_popped_value;
  logic [OUT_CNT_W-1:0]    out_count_after;
  logic                    out_is_empty;
  logic signed [VAL_W-1:0] out_front_value;
  logic signed [VAL_W-1:0] out_back_value;
  logic                    out_overflow;

  int fail_count;
  int results_waiting;
  int results_seen;
  int refused_pushes;
  int empty_pops;
  int peak_fill;
  int cycle_count = 0;
  int requests_sent = 0;

  bit quiet_stretch = 1'b0;
  bit hold_request  = 1'b0;

  double_ended_queue u_top (.*);

  dqe_checker u_check (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_double_ended_queue: timeout after %0d cycles", cycle_count);
      $display("tb_double_ended_queue: FAIL");
      $finish;
    end
  end

  // result side: random stall, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_request = 1'b0;
        out_stall    = 1'b0;
      end else begin
        out_stall = !quiet_stretch && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // value with the field extremes mixed in
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return NONE_VALUE;
      default: return $urandom;
    endcase
  endfunction

  // action drawn from a push/pop mix, the rest split among query and unused codes
  function automatic logic [2:0] pick_action(int push_pct, int pop_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    end else if (roll < push_pct + pop_pct) begin
      return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
    end
    case ($urandom_range(3))
      0:       return ACT_QUERY;
      1:       return ACT_SPARE_A;
      2:       return ACT_SPARE_B;
      default: return ACT_SPARE_C;
    endcase
  endfunction

  // one request transfer, with a possible idle gap ahead of it
  task automatic send_item(logic [2:0] code, logic signed [VAL_W-1:0] value);
    while (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
      in_valid      = 1'b0;
      in_action     = 3'($urandom);
      in_push_value = $urandom;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_action     = code;
    in_push_value = value;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic run_phase(int n_items, int push_pct, int pop_pct);
    repeat (n_items) send_item(pick_action(push_pct, pop_pct), pick_value());
  endtask

  // sender quiet until every outstanding result has arrived
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (results_waiting != 0) @(negedge clk);
  endtask

  // stimulus and verdict
  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty deque: pops, query, unused codes
    send_item(ACT_POP_FRONT, '0);
    send_item(ACT_POP_BACK, VAL_MAX);
    send_item(ACT_QUERY, VAL_MIN);
    send_item(ACT_SPARE_A, NONE_VALUE);
    send_item(ACT_SPARE_B, NONE_VALUE);
    send_item(ACT_SPARE_C, NONE_VALUE);
    // pushes at both ends with extreme values
    send_item(ACT_PUSH_FRONT, VAL_MAX);
    send_item(ACT_PUSH_BACK, VAL_MIN);
    send_item(ACT_PUSH_FRONT, '0);
    send_item(ACT_PUSH_BACK, NONE_VALUE);
    send_item(ACT_QUERY, '0);
    send_item(ACT_SPARE_C, 32'sd1234);
    // drain from both ends, then pop past empty
    send_item(ACT_POP_BACK, '0);
    send_item(ACT_POP_FRONT, '0);
    send_item(ACT_POP_BACK, '0);
    send_item(ACT_POP_FRONT, '0);
    send_item(ACT_POP_FRONT, VAL_MIN);
    send_item(ACT_POP_BACK, VAL_MAX);
    wait_for_results();

    // fill to the top and keep pushing so pushes get refused
    run_phase(420, 85, 10);
    // drain under a long result hold-off so the input backs up
    hold_request = 1'b1;
    run_phase(420, 10, 85);
    // balanced traffic with no idling on either side
    quiet_stretch = 1'b1;
    run_phase(160, 45, 45);
    quiet_stretch = 1'b0;
    wait_for_results();
    run_phase(420, 85, 10);
    run_phase(420, 10, 85);

    wait_for_results();
    repeat (8) @(negedge clk);

    $display("tb_double_ended_queue: %0d requests sent, %0d results checked",
             requests_sent, results_seen);
    $display("tb_double_ended_queue: %0d refused pushes, %0d pops on empty, peak fill %0d of %0d",
             refused_pushes, empty_pops, peak_fill, DEPTH);
    if (fail_count == 0) begin
      $display("tb_double_ended_queue: PASS");
    end else begin
      $display("tb_double_ended_queue: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/dqe_pkg.sv
sv/dqe_cell.sv
sv/dqe_chain.sv
sv/double_ended_queue.sv
verif/dqe_checker.sv
verif/tb_double_ended_queue.sv
